FILE: rtl/pnm_pkg.sv
package pnm_pkg;

	typedef enum logic [2:0] {
		PH_MAGIC  = 3'd0,
		PH_WIDTH  = 3'd1,
		PH_HEIGHT = 3'd2,
		PH_MAXVAL = 3'd3,
		PH_PIXELS = 3'd4,
		PH_DONE   = 3'd5,
		PH_ERROR  = 3'd6
	} phase_t;

	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNSUP = 2'd1;
	localparam logic [1:0] ST_UNIMP = 2'd2;

	localparam logic [1:0] FMT_PBM = 2'd0;
	localparam logic [1:0] FMT_PGM = 2'd1;
	localparam logic [1:0] FMT_PPM = 2'd2;

	// Front-to-back work descriptor.
	typedef enum logic [1:0] {
		OP_HDR  = 2'd0,   // one header/error result
		OP_PIX  = 2'd1,   // one pixel
		OP_BITS = 2'd2    // raw PBM byte: eight pixels, MSB first
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [31:0] pix;
		logic [1:0]  fmt;
		logic        plain;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0]  bits;
		logic        re0;     // for single pixel
		logic        ie0;
		logic [7:0]  re_mask; // per bit of a raw PBM byte
		logic [7:0]  ie_mask;
	} job_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
	endfunction

endpackage

FILE: rtl/pnm_front.sv
module pnm_front #(
	parameter int DIM_BITS  = 16,
	parameter int TOKEN_MAX = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              new_image,
	output logic              job_valid,
	input  logic              job_full,
	output pnm_pkg::job_t     job
);
	localparam int TV_W  = DIM_BITS + 1;
	localparam int TL_W  = $clog2(TOKEN_MAX + 1);
	localparam logic [TV_W-1:0] LIMIT = TV_W'(1) << DIM_BITS;

	pnm_pkg::phase_t phase_q;
	logic [1:0]          fmt_q;
	logic                plain_q;
	logic [DIM_BITS-1:0] width_q, height_q;
	logic [TV_W-1:0]     tval_q;
	logic [TL_W-1:0]     tlen_q;
	logic                magic_q, comment_q, dseen_q;
	logic [DIM_BITS-1:0] col_q, row_q;
	logic [16:0]         samp_q;
	logic [1:0]          comp_q;
	logic [23:0]         rgb_q;

	logic go;
	assign in_stall = job_full;
	assign go = in_valid && !job_full;

	// Pixel position tracking, evaluated in the front so the back only replays.
	function automatic logic [DIM_BITS-1:0] inc(input logic [DIM_BITS-1:0] v);
		return v + DIM_BITS'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		pnm_pkg::phase_t ph;
		logic [1:0] fm; logic pl; logic [DIM_BITS-1:0] w, h, c, r;
		logic [TV_W-1:0] tv, v; logic [TL_W-1:0] tl; logic mo, cm, ds, endt, ok;
		logic [16:0] sv; logic [1:0] ci; logic [23:0] rgb; logic [7:0] b, g;
		logic [TV_W+3:0] prod; logic [20:0] sp;
		pnm_pkg::job_t j; logic jv; logic [31:0] px; logic dopix;
		if (!arst_n) begin
			phase_q <= pnm_pkg::PH_MAGIC; fmt_q <= '0; plain_q <= 1'b0;
			width_q <= '0; height_q <= '0; tval_q <= '0; tlen_q <= '0;
			magic_q <= 1'b0; comment_q <= 1'b0; dseen_q <= 1'b0;
			col_q <= '0; row_q <= '0; samp_q <= '0; comp_q <= '0; rgb_q <= '0;
			job_valid <= 1'b0; job <= '0;
		end else begin
			job_valid <= 1'b0;
			if (go) begin
				ph = phase_q; fm = fmt_q; pl = plain_q; w = width_q; h = height_q;
				tv = tval_q; tl = tlen_q; mo = magic_q; cm = comment_q; ds = dseen_q;
				c = col_q; r = row_q; sv = samp_q; ci = comp_q; rgb = rgb_q;
				b = in_byte; j = '0; jv = 1'b0; endt = 1'b0; px = '0; dopix = 1'b0;
				if (new_image) begin
					ph = pnm_pkg::PH_MAGIC; fm = '0; pl = 1'b0; w = '0; h = '0;
					tv = '0; tl = '0; mo = 1'b0; cm = 1'b0; ds = 1'b0;
					c = '0; r = '0; sv = '0; ci = '0; rgb = '0;
				end
				j.op = pnm_pkg::OP_HDR;
				if (ph == pnm_pkg::PH_DONE || ph == pnm_pkg::PH_ERROR) begin
				end else if (cm) begin
					if (b == 8'h0a) cm = 1'b0;
				end else if (ph != pnm_pkg::PH_PIXELS) begin
					if (b == 8'h23) begin
						cm = 1'b1; endt = 1'b1;
					end else if (pnm_pkg::is_ws(b)) begin
						endt = 1'b1;
					end else begin
						if (tl == '0) mo = (b == 8'h50);
						if (ph == pnm_pkg::PH_MAGIC) begin
							if (tl == TL_W'(1)) tv = TV_W'(b);
						end else if (!ds && b >= 8'h30 && b <= 8'h39) begin
							prod = (TV_W+4)'(tv) * (TV_W+4)'(10) + (TV_W+4)'(b - 8'h30);
							tv = (prod > (TV_W+4)'(LIMIT)) ? LIMIT : TV_W'(prod);
						end else begin
							ds = 1'b1;
						end
						tl = tl + TL_W'(1);
						if (tl >= TL_W'(TOKEN_MAX)) endt = 1'b1;
					end
					if (endt) begin
						v = tv; ok = mo;
						if (tl != '0) begin
							case (ph)
								pnm_pkg::PH_MAGIC: begin
									if (ok && tl >= TL_W'(2) && v >= TV_W'(8'h31)
											&& v <= TV_W'(8'h36)) begin
										case (v[2:0])
											3'd1, 3'd4: fm = pnm_pkg::FMT_PBM;
											3'd2, 3'd5: fm = pnm_pkg::FMT_PGM;
											default:    fm = pnm_pkg::FMT_PPM;
										endcase
										pl = (v <= TV_W'(8'h33));
										ph = pnm_pkg::PH_WIDTH;
									end else begin
										jv = 1'b1; j.kind = pnm_pkg::KIND_ERROR;
										j.status = pnm_pkg::ST_UNSUP; ph = pnm_pkg::PH_ERROR;
									end
								end
								pnm_pkg::PH_WIDTH: begin
									if (v == '0 || v >= LIMIT) begin
										jv = 1'b1; j.kind = pnm_pkg::KIND_ERROR;
										j.status = pnm_pkg::ST_UNSUP; ph = pnm_pkg::PH_ERROR;
									end else if (fm == pnm_pkg::FMT_PBM && v[2:0] != 3'd0) begin
										jv = 1'b1; j.kind = pnm_pkg::KIND_ERROR;
										j.status = pnm_pkg::ST_UNIMP; ph = pnm_pkg::PH_ERROR;
									end else begin
										w = v[DIM_BITS-1:0]; ph = pnm_pkg::PH_HEIGHT;
									end
								end
								pnm_pkg::PH_HEIGHT: begin
									if (v == '0 || v >= LIMIT) begin
										jv = 1'b1; j.kind = pnm_pkg::KIND_ERROR;
										j.status = pnm_pkg::ST_UNSUP; ph = pnm_pkg::PH_ERROR;
									end else begin
										h = v[DIM_BITS-1:0];
										if (fm == pnm_pkg::FMT_PBM) begin
											jv = 1'b1; j.kind = pnm_pkg::KIND_HEADER;
											ph = pnm_pkg::PH_PIXELS;
											c = '0; r = '0; sv = '0; ci = '0; rgb = '0;
										end else ph = pnm_pkg::PH_MAXVAL;
									end
								end
								pnm_pkg::PH_MAXVAL: begin
									if (v == '0) begin
										jv = 1'b1; j.kind = pnm_pkg::KIND_ERROR;
										j.status = pnm_pkg::ST_UNSUP; ph = pnm_pkg::PH_ERROR;
									end else if (v > TV_W'(255)) begin
										jv = 1'b1; j.kind = pnm_pkg::KIND_ERROR;
										j.status = pnm_pkg::ST_UNIMP; ph = pnm_pkg::PH_ERROR;
									end else begin
										jv = 1'b1; j.kind = pnm_pkg::KIND_HEADER;
										ph = pnm_pkg::PH_PIXELS;
										c = '0; r = '0; sv = '0; ci = '0; rgb = '0;
									end
								end
								default: ;
							endcase
						end
						tv = '0; tl = '0; mo = 1'b0; ds = 1'b0;
					end
				end else begin
					// raster
					if (!pl && fm == pnm_pkg::FMT_PBM) begin
						// widths are multiples of 8: a byte never splits a row
						j.op = pnm_pkg::OP_BITS; j.bits = b; jv = 1'b1;
						c = c + DIM_BITS'(8);
						if (c >= w) begin
							c = '0; r = inc(r);
							j.re_mask = 8'h01;
							if (r >= h) begin
								j.ie_mask = 8'h01; ph = pnm_pkg::PH_DONE;
							end
						end
					end else begin
						if (!pl) begin
							g = b; dopix = 1'b1;
						end else if (fm == pnm_pkg::FMT_PBM) begin
							if (b == 8'h30 || b == 8'h31) begin
								dopix = 1'b1; g = (b == 8'h30) ? 8'hff : 8'h00;
							end else g = '0;
						end else if (b >= 8'h30 && b <= 8'h39) begin
							sp = {sv, 2'b00} + 21'(sv);
							sp = {sp[19:0], 1'b0} + 21'(b - 8'h30);
							sv = sp[16:0]; ds = 1'b1; g = '0;
						end else if (pnm_pkg::is_ws(b) && ds) begin
							g = sv[7:0]; sv = '0; ds = 1'b0; dopix = 1'b1;
						end else begin
							sv = '0; ds = 1'b0; g = '0;
						end
						if (dopix) begin
							if (fm == pnm_pkg::FMT_PPM) begin
								case (ci)
									2'd0: rgb[23:16] = g;
									2'd1: rgb[15:8] = g;
									default: rgb[7:0] = g;
								endcase
								if (ci == 2'd2) begin
									px = {8'hff, rgb}; ci = '0; rgb = '0;
								end else begin
									ci = ci + 2'd1; dopix = 1'b0;
								end
							end else px = {g, g, g, g};
						end
						if (dopix) begin
							jv = 1'b1; j.op = pnm_pkg::OP_PIX; j.pix = px;
							c = inc(c);
							if (c >= w) begin
								c = '0; r = inc(r); j.re0 = 1'b1;
								if (r >= h) begin
									j.ie0 = 1'b1; ph = pnm_pkg::PH_DONE;
								end
							end
						end
					end
				end
				j.fmt = fm; j.plain = pl;
				j.width = 16'(w); j.height = 16'(h);
				phase_q <= ph; fmt_q <= fm; plain_q <= pl; width_q <= w; height_q <= h;
				tval_q <= tv; tlen_q <= tl; magic_q <= mo; comment_q <= cm;
				dseen_q <= ds; col_q <= c; row_q <= r; samp_q <= sv; comp_q <= ci;
				rgb_q <= rgb;
				job_valid <= jv; job <= j;
			end
		end
	end
endmodule

FILE: rtl/pnm_fifo.sv
module pnm_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  pnm_pkg::job_t wr_data,
	output logic          almost_full,
	input  logic          rd_en,
	output logic          rd_valid,
	output pnm_pkg::job_t rd_data
);
	// four entries; front has one job in its output register, so stall at two used
	pnm_pkg::job_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 2'd1;
			if (rd_en) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr_en) - 3'(rd_en);
		end
	end

	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign almost_full = (cnt_q >= 3'd2);
endmodule

FILE: rtl/pnm_back.sv
module pnm_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  pnm_pkg::job_t job,
	output logic          job_take,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    out_kind,
	output logic [31:0]   argb,
	output logic          row_end,
	output logic          image_end,
	output logic          run_last,
	output logic [1:0]    status,
	output logic [1:0]    image_format,
	output logic          plain_text,
	output logic [15:0]   image_width,
	output logic [15:0]   image_height
);
	logic [2:0] bit_q;   // bit index within a raw PBM byte, counting down
	logic       busy_q;
	logic       load;
	logic       last;
	logic [2:0] k;

	assign load = !out_valid || !out_stall;
	assign k = busy_q ? bit_q : 3'd7;
	assign last = (job.op != pnm_pkg::OP_BITS) || (k == 3'd0);
	assign job_take = job_valid && load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0; busy_q <= 1'b0; bit_q <= '0;
		end else if (load) begin
			out_valid <= job_valid;
			if (job_valid) begin
				busy_q <= !last;
				bit_q <= k - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && job_valid) begin
			out_kind     <= (job.op == pnm_pkg::OP_HDR) ? job.kind : pnm_pkg::KIND_PIXEL;
			status       <= (job.op == pnm_pkg::OP_HDR) ? job.status : pnm_pkg::ST_OK;
			image_format <= job.fmt;
			plain_text   <= job.plain;
			image_width  <= job.width;
			image_height <= job.height;
			run_last     <= last;
			case (job.op)
				pnm_pkg::OP_BITS: begin
					argb       <= job.bits[k] ? 32'h0000_0000 : 32'hffff_ffff;
					row_end    <= job.re_mask[k];
					image_end  <= job.ie_mask[k];
				end
				pnm_pkg::OP_PIX: begin
					argb <= job.pix; row_end <= job.re0; image_end <= job.ie0;
				end
				default: begin
					argb <= '0; row_end <= 1'b0; image_end <= 1'b0;
				end
			endcase
		end
	end
endmodule

FILE: rtl/pnm_stream_to_argb_decoder.sv
// PNM (P1..P6) byte-stream decoder producing 32-bit ARGB pixels. Bytes enter
// at one per cycle while in_stall is low; the front parser classifies each
// byte, tracks header tokens, row and column counts, and emits at most one
// work transaction into a four-entry queue. The back end expands each into
// results at one per cycle while out_stall is low: one for a header, error
// or pixel transaction, eight for a raw PBM byte, and no new transaction is
// taken until those eight are out; raw PBM input stalls once the queue fills.
// Assert new_image with the first byte of every file; after the image end or
// an error, bytes are consumed silently until the next new_image.
module pnm_stream_to_argb_decoder #(
	parameter int DIM_BITS  = 16,
	parameter int TOKEN_MAX = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        new_image,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [31:0] argb,
	output logic        row_end,
	output logic        image_end,
	output logic        run_last,
	output logic [1:0]  status,
	output logic [1:0]  image_format,
	output logic        plain_text,
	output logic [15:0] image_width,
	output logic [15:0] image_height
);
	logic          f_valid, q_full, q_valid, q_take;
	pnm_pkg::job_t f_job, q_job;

	// front: header parse and raster classification
	pnm_front #(.DIM_BITS(DIM_BITS), .TOKEN_MAX(TOKEN_MAX)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_byte, .new_image,
		.job_valid(f_valid), .job_full(q_full), .job(f_job)
	);

	// decoupling queue
	pnm_fifo u_fifo (
		.clk, .arst_n, .wr_en(f_valid), .wr_data(f_job), .almost_full(q_full),
		.rd_en(q_take), .rd_valid(q_valid), .rd_data(q_job)
	);

	// back: result expansion and output register
	pnm_back u_back (
		.clk, .arst_n, .job_valid(q_valid), .job(q_job), .job_take(q_take),
		.out_valid, .out_stall, .out_kind, .argb, .row_end, .image_end,
		.run_last, .status, .image_format, .plain_text, .image_width, .image_height
	);
endmodule

FILE: rtl/pnm_checker.sv
module pnm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  out_kind,
	input logic [31:0] argb,
	input logic        row_end,
	input logic        image_end,
	input logic [1:0]  status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(argb))
		else $error("stalled result changed");
	a_ie_re: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end && out_kind == pnm_pkg::KIND_PIXEL)
		else $error("image end without row end");
	a_err_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == pnm_pkg::KIND_ERROR |-> status != pnm_pkg::ST_OK)
		else $error("error with ok status");
	a_pix_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != pnm_pkg::KIND_ERROR |-> status == pnm_pkg::ST_OK)
		else $error("status on non-error");
endmodule

bind pnm_stream_to_argb_decoder pnm_checker u_checker (
	.clk, .arst_n, .out_valid, .out_stall, .out_kind, .argb,
	.row_end, .image_end, .status
);

FILE: bench/pnm_decode_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the decoder, predicts the result stream and
// compares it with what comes out.
module pnm_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        new_image,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  out_kind,
	input  logic [31:0] argb,
	input  logic        row_end,
	input  logic        image_end,
	input  logic        run_last,
	input  logic [1:0]  status,
	input  logic [1:0]  image_format,
	input  logic        plain_text,
	input  logic [15:0] image_width,
	input  logic [15:0] image_height,
	output int          mismatches,
	output int          pending
);

	localparam int TOKEN_MAX = 32;
	localparam logic [16:0] DIM_LIMIT = 17'h10000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] pix;
		logic        re;
		logic        ie;
		logic        last;
		logic [1:0]  st;
		logic [1:0]  fmt;
		logic        plain;
		logic [15:0] wid;
		logic [15:0] hgt;
	} result_t;

	result_t predicted_q[$];

	// decoder state
	pnm_pkg::phase_t ph;
	logic [1:0]  fmt;
	logic        plain;
	logic [15:0] wid, hgt;
	logic [16:0] tok_val;
	logic [5:0]  tok_len;
	logic        magic_p;
	logic        skip_cmt;
	logic [15:0] col, row;
	logic [16:0] smp;
	logic        got_digit;
	logic [1:0]  comp_idx;
	logic [23:0] rgb_acc;
	int          n_now;

	function automatic logic is_space(logic [7:0] b);
		return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic void clear_state();
		ph = pnm_pkg::PH_MAGIC;
		fmt = pnm_pkg::FMT_PBM;
		plain = 1'b0;
		wid = '0;
		hgt = '0;
		tok_val = '0;
		tok_len = '0;
		magic_p = 1'b0;
		skip_cmt = 1'b0;
		col = '0;
		row = '0;
		smp = '0;
		got_digit = 1'b0;
		comp_idx = '0;
		rgb_acc = '0;
	endfunction

	function automatic void emit(logic [1:0] kind, logic [31:0] pix, logic re, logic ie,
			logic [1:0] st);
		predicted_q.push_back('{kind, pix, re, ie, 1'b0, st, fmt, plain, wid, hgt});
		n_now++;
	endfunction

	function automatic void raise_error(logic [1:0] st);
		emit(pnm_pkg::KIND_ERROR, 32'h0, 1'b0, 1'b0, st);
		ph = pnm_pkg::PH_ERROR;
	endfunction

	function automatic void header_ok();
		emit(pnm_pkg::KIND_HEADER, 32'h0, 1'b0, 1'b0, pnm_pkg::ST_OK);
		ph = pnm_pkg::PH_PIXELS;
		col = '0;
		row = '0;
		smp = '0;
		got_digit = 1'b0;
		comp_idx = '0;
		rgb_acc = '0;
	endfunction

	function automatic void close_token();
		logic [16:0] v;
		logic [5:0]  len;
		logic        okp;
		v = tok_val;
		len = tok_len;
		okp = magic_p;
		tok_val = '0;
		tok_len = '0;
		magic_p = 1'b0;
		got_digit = 1'b0;
		if (len == 0)
			return;
		case (ph)
			pnm_pkg::PH_MAGIC: begin
				if (okp && len >= 2 && v >= 17'h31 && v <= 17'h36) begin
					fmt = 2'((v - 17'h31) % 3);
					plain = (v <= 17'h33);
					ph = pnm_pkg::PH_WIDTH;
				end else
					raise_error(pnm_pkg::ST_UNSUP);
			end
			pnm_pkg::PH_WIDTH: begin
				if (v == 0 || v >= DIM_LIMIT)
					raise_error(pnm_pkg::ST_UNSUP);
				else if (fmt == pnm_pkg::FMT_PBM && v[2:0] != 3'd0)
					raise_error(pnm_pkg::ST_UNIMP);
				else begin
					wid = v[15:0];
					ph = pnm_pkg::PH_HEIGHT;
				end
			end
			pnm_pkg::PH_HEIGHT: begin
				if (v == 0 || v >= DIM_LIMIT)
					raise_error(pnm_pkg::ST_UNSUP);
				else begin
					hgt = v[15:0];
					if (fmt == pnm_pkg::FMT_PBM)
						header_ok();
					else
						ph = pnm_pkg::PH_MAXVAL;
				end
			end
			pnm_pkg::PH_MAXVAL: begin
				if (v == 0)
					raise_error(pnm_pkg::ST_UNSUP);
				else if (v > 255)
					raise_error(pnm_pkg::ST_UNIMP);
				else
					header_ok();
			end
			default: ;
		endcase
	endfunction

	function automatic void header_char(logic [7:0] b);
		int unsigned t;
		if (b == "#") begin
			skip_cmt = 1'b1;
			close_token();
			return;
		end
		if (is_space(b)) begin
			close_token();
			return;
		end
		if (tok_len == 0)
			magic_p = (b == "P");
		if (ph == pnm_pkg::PH_MAGIC) begin
			if (tok_len == 1)
				tok_val = 17'(b);
		end else if (!got_digit && b >= "0" && b <= "9") begin
			t = tok_val * 10 + (b - "0");
			if (t > DIM_LIMIT)
				t = 32'(DIM_LIMIT);
			tok_val = t[16:0];
		end else
			got_digit = 1'b1;
		tok_len++;
		if (tok_len >= TOKEN_MAX)
			close_token();
	endfunction

	function automatic void put_pixel(logic [31:0] p);
		logic re, ie;
		if (ph != pnm_pkg::PH_PIXELS)
			return;
		col++;
		re = (col >= wid);
		ie = 1'b0;
		if (re) begin
			col = '0;
			row++;
			if (row >= hgt) begin
				ie = 1'b1;
				ph = pnm_pkg::PH_DONE;
			end
		end
		emit(pnm_pkg::KIND_PIXEL, p, re, ie, pnm_pkg::ST_OK);
	endfunction

	function automatic void add_component(logic [7:0] c);
		rgb_acc |= 24'(c) << (16 - 8 * comp_idx);
		comp_idx++;
		if (comp_idx >= 3) begin
			comp_idx = '0;
			put_pixel({8'hff, rgb_acc});
			rgb_acc = '0;
		end
	endfunction

	function automatic void raster_char(logic [7:0] b);
		int unsigned t;
		logic [7:0]  g;
		if (!plain) begin
			if (fmt == pnm_pkg::FMT_PBM) begin
				for (int k = 7; k >= 0 && ph == pnm_pkg::PH_PIXELS; k--)
					put_pixel(b[k] ? 32'h0000_0000 : 32'hffff_ffff);
			end else if (fmt == pnm_pkg::FMT_PGM)
				put_pixel({4{b}});
			else
				add_component(b);
			return;
		end
		if (fmt == pnm_pkg::FMT_PBM) begin
			if (b == "0")
				put_pixel(32'hffff_ffff);
			else if (b == "1")
				put_pixel(32'h0000_0000);
			return;
		end
		if (b >= "0" && b <= "9") begin
			t = smp * 10 + (b - "0");
			smp = t[16:0];
			got_digit = 1'b1;
		end else if (is_space(b) && got_digit) begin
			g = smp[7:0];
			smp = '0;
			got_digit = 1'b0;
			if (fmt == pnm_pkg::FMT_PGM)
				put_pixel({4{g}});
			else
				add_component(g);
		end else begin
			smp = '0;
			got_digit = 1'b0;
		end
	endfunction

	// one accepted input transaction -> zero or more predicted results
	function automatic void decode_byte(logic [7:0] b, logic ni);
		if (ni)
			clear_state();
		n_now = 0;
		if (ph == pnm_pkg::PH_DONE || ph == pnm_pkg::PH_ERROR)
			return;
		if (skip_cmt) begin
			if (b == 8'h0a)
				skip_cmt = 1'b0;
			return;
		end
		if (ph == pnm_pkg::PH_PIXELS)
			raster_char(b);
		else
			header_char(b);
		if (n_now > 0)
			predicted_q[predicted_q.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	initial begin
		mismatches = 0;
		clear_state();
	end

	assign pending = predicted_q.size();

	always @(posedge clk) begin
		result_t e;
		if (!arst_n)
			clear_state();
		else begin
			if (in_valid && !in_stall)
				decode_byte(in_byte, new_image);
			if (out_valid && !out_stall) begin
				if (predicted_q.size() == 0)
					report_mismatch("result with nothing predicted");
				else begin
					e = predicted_q.pop_front();
					check_field("out_kind", 32'(out_kind), 32'(e.kind));
					check_field("argb", argb, e.pix);
					check_field("row_end", 32'(row_end), 32'(e.re));
					check_field("image_end", 32'(image_end), 32'(e.ie));
					check_field("run_last", 32'(run_last), 32'(e.last));
					check_field("status", 32'(status), 32'(e.st));
					check_field("image_format", 32'(image_format), 32'(e.fmt));
					check_field("plain_text", 32'(plain_text), 32'(e.plain));
					check_field("image_width", 32'(image_width), 32'(e.wid));
					check_field("image_height", 32'(image_height), 32'(e.hgt));
				end
			end
		end
	end

endmodule

FILE: bench/pnm_stream_to_argb_decoder_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the PNM decoder. Whole files (valid, truncated,
// malformed and plain noise) are queued as byte transactions and pushed
// through the input channel; the checker beside the DUT does all predicting.
module pnm_stream_to_argb_decoder_tb;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  in_byte;
	logic        new_image;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  out_kind;
	logic [31:0] argb;
	logic        row_end;
	logic        image_end;
	logic        run_last;
	logic [1:0]  status;
	logic [1:0]  image_format;
	logic        plain_text;
	logic [15:0] image_width;
	logic [15:0] image_height;
	int          mismatches;
	int          pending;

	typedef struct {
		logic [7:0] b;
		logic       ni;
	} file_byte_t;

	file_byte_t byte_q[$];    // transactions waiting to be offered
	logic       first_flag;   // next queued byte opens a file
	int         tx_idle_pct;
	int         rx_idle_pct;
	logic       hold_on;      // long receiver hold-off in progress
	int         cycles;
	event       hold_trigger;

	pnm_stream_to_argb_decoder u_dut (.*);

	pnm_decode_checker u_chk (.*);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// hard stop in case the handshake hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("pnm_stream_to_argb_decoder_tb NOT OK");
			$finish;
		end
	end

	// receiver side: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= hold_on || ($urandom_range(99) < rx_idle_pct);
	end

	initial begin
		hold_on = 1'b0;
		forever begin
			@(hold_trigger);
			@(posedge clk);
			hold_on <= 1'b1;
			repeat (300) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// --- file builders ---------------------------------------------------

	function automatic void open_file();
		first_flag = 1'b1;
	endfunction

	function automatic void add_byte(logic [7:0] b);
		byte_q.push_back('{b, first_flag});
		first_flag = 1'b0;
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	// header separator; sometimes a comment
	function automatic string pick_sep();
		case ($urandom_range(0, 6))
			0: return " ";
			1: return "\n";
			2: return "\t";
			3: return "\r\n";
			4: return "  ";
			5: return " # note\n";
			default: return $sformatf("%c", 8'd11);
		endcase
	endfunction

	function automatic void gen_file();
		int r, m, w, h, mx, n;
		logic [1:0] f;
		logic pl;
		r = $urandom_range(99);
		open_file();
		if (r < 8) begin
			// noise: random bytes, mostly a bad magic
			repeat ($urandom_range(1, 12))
				add_byte(8'($urandom_range(0, 255)));
			return;
		end
		m = $urandom_range(1, 6);
		f = 2'((m - 1) % 3);
		pl = (m <= 3);
		w = (f == pnm_pkg::FMT_PBM) ? 8 * $urandom_range(1, 2) : $urandom_range(1, 4);
		h = $urandom_range(1, 3);
		mx = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 255);
		if (r < 16) begin
			// header likely to be refused
			w = $urandom_range(0, 12);
			mx = $urandom_range(0, 400);
		end
		add_text($sformatf("P%0d%s%0d%s%0d", m, pick_sep(), w, pick_sep(), h));
		if (f != pnm_pkg::FMT_PBM)
			add_text($sformatf("%s%0d", pick_sep(), mx));
		add_text(pl ? pick_sep() : ($urandom_range(1) ? " " : "\n"));
		if (f == pnm_pkg::FMT_PBM && !pl)
			n = (w / 8) * h;
		else
			n = w * h * (f == pnm_pkg::FMT_PPM ? 3 : 1);
		if (r < 22)
			n = n / 2;   // truncated raster
		for (int i = 0; i < n; i++) begin
			if (!pl)
				add_byte(8'($urandom_range(0, 255)));
			else if (f == pnm_pkg::FMT_PBM) begin
				add_byte($urandom_range(1) ? "1" : "0");
				if ($urandom_range(3) == 0)
					add_text($urandom_range(3) == 0 ? "x" : " ");
			end else begin
				if ($urandom_range(15) == 0)
					add_text("7x");   // garbage sample, dropped
				add_text($sformatf("%0d%s", $urandom_range(0, 999),
					$urandom_range(1) ? " " : "\n"));
			end
		end
		if ($urandom_range(4) == 0)
			add_text(" 5 1 ");   // trailing bytes after the image
	endfunction

	function automatic void build_directed();
		open_file(); add_text("P5 2 1 255 "); add_byte(8'h00); add_byte(8'hff);
		open_file(); add_text("P4 8 1\n"); add_byte(8'ha5);
		open_file(); add_text("P6 1 1 255\n"); add_byte(8'h12); add_byte(8'h34);
		add_byte(8'h56);
		open_file(); add_text("P1 8 1#c\n1010 01x01");
		open_file(); add_text("P2 1 1 9 300 ");
		open_file(); add_text("P3 1 1 1 1 2 3 ");
		open_file(); add_text("X1 ");
		open_file(); add_text("P7 ");
		open_file(); add_text("P5 0 ");
		open_file(); add_text("P5 70000 ");
		open_file(); add_text("P4 5 ");
		open_file(); add_text("P5 -3 ");
		open_file(); add_text("P5 1 1 256 ");
		open_file(); add_text("P5 1 1 0 ");
		// over-long token: cut after 32 zeros, reads as 0
		open_file(); add_text("P5 000000000000000000000000000000001 ");
	endfunction

	// --- driving ---------------------------------------------------------

	task automatic send_all();
		file_byte_t s;
		while (byte_q.size() > 0) begin
			s = byte_q.pop_front();
			in_valid <= 1'b1;
			in_byte <= s.b;
			new_image <= s.ni;
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			if (byte_q.size() == 0 || $urandom_range(99) < tx_idle_pct) begin
				in_valid <= 1'b0;
				if (byte_q.size() != 0)
					repeat ($urandom_range(1, 3)) @(posedge clk);
			end
		end
	endtask

	// sender pause: nothing offered until every predicted result is out
	task automatic wait_drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic random_phase(int nbytes);
		while (byte_q.size() < nbytes)
			gen_file();
		send_all();
		wait_drain();
	endtask

	initial begin
		cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		new_image = 1'b0;
		tx_idle_pct = 38;
		rx_idle_pct = 50;
		first_flag = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_directed();
		send_all();
		wait_drain();

		// long receiver hold-off under raw PBM: the work queue fills and the
		// input stalls while bytes keep coming
		tx_idle_pct = 0;
		->hold_trigger;
		open_file();
		add_text("P4 16 4\n");
		repeat (8) add_byte(8'($urandom_range(0, 255)));
		send_all();
		wait_drain();

		tx_idle_pct = 50;
		rx_idle_pct = 38;
		random_phase(8);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(8);

		if (mismatches == 0 && pending == 0)
			$display("pnm_stream_to_argb_decoder_tb OK");
		else
			$display("pnm_stream_to_argb_decoder_tb NOT OK");
		$finish;
	end

endmodule
